FILE: rtl/core/rrncm_pkg.sv
// rrncm_pkg: shared types and constants for the raster rotate nearest cell map
// no dependencies
package rrncm_pkg;

    localparam int MAX_COLS       = 64;
    localparam int MAX_ROWS       = 64;
    localparam int TRIG_FRAC_BITS = 16;

    localparam int COORD_W = 24;
    localparam int TRIG_W  = 18;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 12;
    localparam int MAP_W   = 13;
    localparam int DIST_W  = 50;
    // rotated position error and squared distance sum widths
    localparam int ERR_W   = 28;
    localparam int SQ_W    = 53;

    typedef enum logic [1:0] {
        OP_LOAD_COL  = 2'd0,
        OP_LOAD_ROW  = 2'd1,
        OP_LOAD_CELL = 2'd2,
        OP_QUERY     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_COS    = 3'd0,
        REG_SIN    = 3'd1,
        REG_CX     = 3'd2,
        REG_CY     = 3'd3,
        REG_COLS   = 3'd4,
        REG_ROWS   = 3'd5,
        REG_NODATA = 3'd6
    } reg_addr_t;

    typedef struct packed {
        logic [1:0]                operation;
        logic [IDX_W-1:0]          index;
        logic signed [COORD_W-1:0] coordinate;
        logic                      mask_bit;
        logic signed [DATA_W-1:0]  cell_data;
    } in_req_t;

    typedef struct packed {
        logic signed [MAP_W-1:0]  map_index;
        logic signed [DATA_W-1:0] out_value;
    } out_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QREAD,
        ST_QCOORD,
        ST_SCAN,
        ST_DRAIN,
        ST_VREAD,
        ST_OUT
    } state_t;

    // one scan candidate travelling through the distance pipeline
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] k;
        logic             last;
    } cand_t;

endpackage

FILE: rtl/core/rrncm_dist.sv
// rrncm_dist: pipelined rotation and squared distance of one cell per cycle
// depends on rrncm_pkg
module rrncm_dist (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rrncm_pkg::cand_t                    cand,
    input  logic signed [rrncm_pkg::COORD_W-1:0] cx_in,
    input  logic signed [rrncm_pkg::COORD_W-1:0] cy_in,
    input  logic signed [rrncm_pkg::COORD_W-1:0] x_in,
    input  logic signed [rrncm_pkg::COORD_W-1:0] y_in,
    input  logic signed [rrncm_pkg::COORD_W-1:0] qx,
    input  logic signed [rrncm_pkg::COORD_W-1:0] qy,
    input  logic signed [rrncm_pkg::TRIG_W-1:0]  cos_v,
    input  logic signed [rrncm_pkg::TRIG_W-1:0]  sin_v,
    output rrncm_pkg::cand_t                    cand_o,
    output logic [rrncm_pkg::SQ_W-1:0]          dist_o
);
    import rrncm_pkg::*;

    // stage 1: offsets
    cand_t             c1_reg;
    logic signed [24:0] dx_reg, dy_reg;
    // stage 2: four products, floor shifted
    cand_t             c2_reg;
    logic signed [42:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    // stage 3: rotated position error
    cand_t             c3_reg;
    logic signed [ERR_W-1:0] ex_reg, ey_reg;
    // stage 4: squares
    cand_t             c4_reg;
    logic [SQ_W-2:0]    sx_reg, sy_reg;

    logic signed [42:0] m_xc, m_ys, m_xs, m_yc;
    logic signed [ERR_W-1:0] rx, ry;

    assign m_xc = 43'(dx_reg * cos_v) >>> TRIG_FRAC_BITS;
    assign m_ys = 43'(dy_reg * sin_v) >>> TRIG_FRAC_BITS;
    assign m_xs = 43'(dx_reg * sin_v) >>> TRIG_FRAC_BITS;
    assign m_yc = 43'(dy_reg * cos_v) >>> TRIG_FRAC_BITS;
    // with cos and sin within +/-1, shifted products stay within 25 bits, rotated positions within 27
    assign rx = ERR_W'(cx_in) + ERR_W'(p_xc_reg) + ERR_W'(p_ys_reg);
    assign ry = ERR_W'(cy_in) - ERR_W'(p_xs_reg) + ERR_W'(p_yc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else
        begin
            c1_reg <= cand;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg   <= 25'(x_in) - 25'(cx_in);
        dy_reg   <= 25'(y_in) - 25'(cy_in);
        p_xc_reg <= m_xc;
        p_ys_reg <= m_ys;
        p_xs_reg <= m_xs;
        p_yc_reg <= m_yc;
        ex_reg   <= ERR_W'(qx) - rx;
        ey_reg   <= ERR_W'(qy) - ry;
        sx_reg   <= (SQ_W-1)'(ex_reg * ex_reg);
        sy_reg   <= (SQ_W-1)'(ey_reg * ey_reg);
    end

    // with cos and sin within +/-1, errors stay below 3*2^24, so each square fits 52 bits and the sum 53
    assign cand_o = c4_reg;
    assign dist_o = SQ_W'(sx_reg) + SQ_W'(sy_reg);
endmodule

FILE: rtl/core/raster_rotate_nearest_cell_map_top.sv
// raster_rotate_nearest_cell_map_top: load stores, scan grid, answer queries
// depends on rrncm_pkg and rrncm_dist
// one request at a time: a new request stalls until the block is idle and the output register is empty
// reset: registers take their defaults, stores hold undefined data until written
// stores are synchronous memories with registered read data
module raster_rotate_nearest_cell_map_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rrncm_pkg::in_req_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rrncm_pkg::out_req_t   out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import rrncm_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int KW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------- configuration registers ----------------
    logic signed [TRIG_W-1:0]  cos_reg, sin_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic [6:0]                cols_cfg_reg, rows_cfg_reg;
    logic signed [DATA_W-1:0]  nodata_reg;
    logic                      wr_en;
    reg_addr_t                 raddr;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign raddr  = reg_addr_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg      <= TRIG_W'(1 << TRIG_FRAC_BITS);
            sin_reg      <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            cols_cfg_reg <= 7'd64;
            rows_cfg_reg <= 7'd64;
            nodata_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (raddr)
                REG_COS:    cos_reg      <= pwdata[TRIG_W-1:0];
                REG_SIN:    sin_reg      <= pwdata[TRIG_W-1:0];
                REG_CX:     cx_reg       <= pwdata[COORD_W-1:0];
                REG_CY:     cy_reg       <= pwdata[COORD_W-1:0];
                REG_COLS:   cols_cfg_reg <= pwdata[6:0];
                REG_ROWS:   rows_cfg_reg <= pwdata[6:0];
                REG_NODATA: nodata_reg   <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (raddr)
            REG_COS:    prdata = 32'(cos_reg);
            REG_SIN:    prdata = 32'(sin_reg);
            REG_CX:     prdata = 32'(cx_reg);
            REG_CY:     prdata = 32'(cy_reg);
            REG_COLS:   prdata = 32'(cols_cfg_reg);
            REG_ROWS:   prdata = 32'(rows_cfg_reg);
            REG_NODATA: prdata = nodata_reg;
            default:    prdata = '0;
        endcase
    end

    // grid size saturated into the supported range, zero acts as one
    logic [10:0] cols, rows;
    logic [21:0] size;
    always_comb
    begin
        cols = (cols_cfg_reg == 7'd0) ? 11'd1 : 11'(cols_cfg_reg);
        if (cols > 11'(MAX_COLS))
            cols = 11'(MAX_COLS);
        rows = (rows_cfg_reg == 7'd0) ? 11'd1 : 11'(rows_cfg_reg);
        if (rows > 11'(MAX_ROWS))
            rows = 11'(MAX_ROWS);
    end
    assign size = 22'(cols * rows);

    // ---------------- stores ----------------
    logic signed [COORD_W-1:0] colx_mem [MAX_COLS];
    logic signed [COORD_W-1:0] rowy_mem [MAX_ROWS];
    logic                      mask_mem [DEPTH];
    logic signed [DATA_W-1:0]  val_mem  [DEPTH];

    logic [CW-1:0]             col_ra;
    logic [RW-1:0]             row_ra;
    logic [KW-1:0]             cell_ra;
    logic signed [COORD_W-1:0] colx_rd, rowy_rd;
    logic                      mask_rd;
    logic signed [DATA_W-1:0]  val_rd;

    logic   accept;
    op_t    op;
    assign accept = in_valid && !in_stall;
    assign op     = op_t'(in_data.operation);

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_LOAD_COL && 32'(in_data.index) < 32'(MAX_COLS))
            colx_mem[in_data.index[CW-1:0]] <= in_data.coordinate;
        colx_rd <= colx_mem[col_ra];
    end

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_LOAD_ROW && 32'(in_data.index) < 32'(MAX_ROWS))
            rowy_mem[in_data.index[RW-1:0]] <= in_data.coordinate;
        rowy_rd <= rowy_mem[row_ra];
    end

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_LOAD_CELL && 32'(in_data.index) < 32'(DEPTH))
        begin
            mask_mem[in_data.index[KW-1:0]] <= in_data.mask_bit;
            val_mem[in_data.index[KW-1:0]]  <= in_data.cell_data;
        end
        mask_rd <= mask_mem[cell_ra];
        val_rd  <= val_mem[cell_ra];
    end

    // ---------------- query sequencer ----------------
    state_t state_reg, state_next;
    logic [IDX_W-1:0]          qidx_reg;
    logic [IDX_W-1:0]          qc_reg;
    logic [10:0]               qr_reg;
    logic signed [COORD_W-1:0] qx_reg, qy_reg;
    logic [10:0]               sc_reg, sr_reg;
    logic [IDX_W-1:0]          k_reg;
    logic                      masked_reg;
    logic [SQ_W-1:0]           best_reg;
    logic [IDX_W-1:0]          besti_reg;
    logic                      have_reg;
    out_req_t                  out_reg;
    logic                      out_valid_reg;
    logic                      qc_en;
    logic [DIST_W-1:0]         best_distance_reg;

    cand_t           cand, cand_d, cand_o;
    logic [SQ_W-1:0] dist_o;
    logic            scan_last;

    // query cell column and row by repeated subtraction during the read
    // (done before the scan: walk idx down by cols, one row per cycle)
    assign scan_last = (sc_reg == cols - 11'd1) && (sr_reg == rows - 11'd1);

    // coordinate reads for the scan are addressed from the counters, and cand_d meets the registered read data
    // the query cell coordinates are addressed while the split runs, read data in ST_QCOORD
    always_comb
    begin
        col_ra  = sc_reg[CW-1:0];
        row_ra  = sr_reg[RW-1:0];
        cell_ra = qidx_reg[KW-1:0];
        if (state_reg == ST_QREAD)
        begin
            col_ra = qc_reg[CW-1:0];
            row_ra = qr_reg[RW-1:0];
        end
        if (state_reg == ST_VREAD || state_reg == ST_DRAIN)
            cell_ra = besti_reg[KW-1:0];
        if (state_reg == ST_IDLE)
            cell_ra = in_data.index[KW-1:0];
    end

    // candidate aligned with the memory read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cand_d <= '0;
        else
            cand_d <= cand;
    end

    always_comb
    begin
        cand.valid = (state_reg == ST_SCAN);
        cand.k     = k_reg;
        cand.last  = scan_last;
    end

    rrncm_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .cand   (cand_d),
        .cx_in  (cx_reg),
        .cy_in  (cy_reg),
        .x_in   (colx_rd),
        .y_in   (rowy_rd),
        .qx     (qx_reg),
        .qy     (qy_reg),
        .cos_v  (cos_reg),
        .sin_v  (sin_reg),
        .cand_o (cand_o),
        .dist_o (dist_o)
    );

    // in_stall: only idle with an empty output register takes a request
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && op == OP_QUERY)
                    state_next = ST_QREAD;
            ST_QREAD:
                if (masked_reg || !mask_rd)
                    state_next = ST_OUT;
                else if (qc_en)
                    state_next = ST_QCOORD;
            ST_QCOORD:
                state_next = ST_SCAN;
            ST_SCAN:
                if (scan_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (cand_o.valid && cand_o.last)
                    state_next = ST_VREAD;
            ST_VREAD:
                state_next = ST_OUT;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // column/row split done when remainder drops below cols
    assign qc_en = (qc_reg < IDX_W'(cols));

    logic better;
    assign better = !have_reg || (dist_o < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            have_reg          <= 1'b0;
            best_distance_reg <= '0;
            besti_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    have_reg <= 1'b0;
                ST_DRAIN:
                    if (cand_o.valid && better)
                    begin
                        have_reg  <= 1'b1;
                        besti_reg <= cand_o.k;
                        best_distance_reg <= (dist_o > SQ_W'((64'd1 << DIST_W) - 1))
                            ? DIST_W'((64'd1 << DIST_W) - 1) : dist_o[DIST_W-1:0];
                    end
                ST_SCAN:
                    if (cand_o.valid && better)
                    begin
                        have_reg  <= 1'b1;
                        besti_reg <= cand_o.k;
                        best_distance_reg <= (dist_o > SQ_W'((64'd1 << DIST_W) - 1))
                            ? DIST_W'((64'd1 << DIST_W) - 1) : dist_o[DIST_W-1:0];
                    end
                ST_OUT:
                    out_valid_reg <= 1'b1;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                qidx_reg   <= in_data.index;
                qc_reg     <= in_data.index;
                qr_reg     <= '0;
                masked_reg <= (22'(in_data.index) >= size);
                sc_reg     <= '0;
                sr_reg     <= '0;
                k_reg      <= '0;
                // a waiting result holds its payload
                if (!out_valid_reg)
                begin
                    out_reg.map_index <= '1;
                    out_reg.out_value <= nodata_reg;
                end
            end
            ST_QREAD:
                if (!qc_en)
                begin
                    qc_reg <= qc_reg - IDX_W'(cols);
                    qr_reg <= qr_reg + 11'd1;
                end
            ST_QCOORD:
            begin
                qx_reg <= colx_rd;
                qy_reg <= rowy_rd;
            end
            ST_SCAN:
            begin
                k_reg <= k_reg + 1'b1;
                if (sc_reg == cols - 11'd1)
                begin
                    sc_reg <= '0;
                    sr_reg <= sr_reg + 11'd1;
                end
                else
                    sc_reg <= sc_reg + 11'd1;
                if (cand_o.valid && better)
                    best_reg <= dist_o;
            end
            ST_DRAIN:
                if (cand_o.valid && better)
                    best_reg <= dist_o;
            ST_OUT:
                if (have_reg)
                begin
                    out_reg.map_index <= MAP_W'(besti_reg);
                    out_reg.out_value <= val_rd;
                end
            default:
                ;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> in_stall)
        else $error("request taken during scan");
    a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("result without query");
`endif
endmodule

FILE: tb/raster_rotate_nearest_cell_map_top_test.sv
// testbench for raster_rotate_nearest_cell_map_top: loads stores, queries cells,
// predicts each answer with its own rotation and nearest-cell search
// depends on rrncm_pkg and the block's top level
module raster_rotate_nearest_cell_map_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rrncm_pkg::*;

    localparam int GRID_MAX = 64;
    localparam int CELLS = GRID_MAX * GRID_MAX;
    localparam int LIMIT = 4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_req_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    raster_rotate_nearest_cell_map_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // shadow copy of the block's registers and stores
    logic signed [17:0] cos_sh = 18'sd65536;
    logic signed [17:0] sin_sh = '0;
    logic signed [23:0] cx_sh = '0;
    logic signed [23:0] cy_sh = '0;
    logic [6:0] cols_sh = 7'd64;
    logic [6:0] rows_sh = 7'd64;
    logic signed [31:0] nodata_sh = '0;
    logic signed [23:0] col_x [GRID_MAX];
    logic signed [23:0] row_y [GRID_MAX];
    logic cell_mask [CELLS];
    logic signed [31:0] cell_val [CELLS];

    out_req_t expected_answers [$];
    int fail_count = 0;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int stall_pct = 0;

    // floor shift of a product by the trig fraction
    function automatic longint fshift(longint v);
        return v >>> TRIG_FRAC_BITS;
    endfunction

    function automatic int dim_of(logic [6:0] v);
        if (v < 1) return 1;
        if (v > GRID_MAX) return GRID_MAX;
        return int'(v);
    endfunction

    function automatic out_req_t nearest_cell(int q);
        out_req_t r;
        int cols, rows, k, best_k;
        longint qx, qy, dx, dy, rx, ry, ex, ey;
        longint unsigned d, best;
        cols = dim_of(cols_sh);
        rows = dim_of(rows_sh);
        if (q >= cols * rows || !cell_mask[q])
        begin
            r.map_index = -13'sd1;
            r.out_value = nodata_sh;
            return r;
        end
        qx = col_x[q % cols];
        qy = row_y[q / cols];
        best = 0;
        best_k = 0;
        k = 0;
        for (int rr = 0; rr < rows; rr++)
        begin
            for (int cc = 0; cc < cols; cc++)
            begin
                dx = longint'(col_x[cc]) - cx_sh;
                dy = longint'(row_y[rr]) - cy_sh;
                rx = cx_sh + fshift(dx * cos_sh) + fshift(dy * sin_sh);
                ry = cy_sh - fshift(dx * sin_sh) + fshift(dy * cos_sh);
                ex = qx - rx;
                ey = qy - ry;
                d = longint'(ex * ex) + longint'(ey * ey);
                if (k == 0 || d < best)
                begin
                    best = d;
                    best_k = k;
                end
                k++;
            end
        end
        r.map_index = 13'(best_k);
        r.out_value = cell_val[best_k];
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall, compare each accepted answer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                fail_count <= fail_count + 1;
                if (fail_count < 10)
                    $display("unexpected answer %0d %0d", out_data.map_index,
                             out_data.out_value);
            end
            else
            begin
                if (out_data !== expected_answers[0])
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("mismatch: expected idx %0d val %0d, got idx %0d val %0d",
                                 expected_answers[0].map_index,
                                 expected_answers[0].out_value,
                                 out_data.map_index, out_data.out_value);
                end
                void'(expected_answers.pop_front());
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // send one request, updating the shadow state when it is accepted
    // valid stays high afterwards until the next request or an idle point drops it
    task automatic send_req(input op_t op, input int idx, input logic [23:0] crd,
                            input logic m, input logic [31:0] val);
        in_req_t r;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        r.operation = op;
        r.index = IDX_W'(idx);
        r.coordinate = crd;
        r.mask_bit = m;
        r.cell_data = val;
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (op)
            OP_LOAD_COL: if (idx < GRID_MAX) col_x[idx] = crd;
            OP_LOAD_ROW: if (idx < GRID_MAX) row_y[idx] = crd;
            OP_LOAD_CELL:
            begin
                cell_mask[idx] = m;
                cell_val[idx] = val;
            end
            default: expected_answers.push_back(nearest_cell(idx));
        endcase
    endtask

    // register write while idle, latency pause first so loads have settled
    task automatic write_reg(input reg_addr_t a, input logic [31:0] v);
        in_valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {a, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (a)
            REG_COS: cos_sh = v[17:0];
            REG_SIN: sin_sh = v[17:0];
            REG_CX: cx_sh = v[23:0];
            REG_CY: cy_sh = v[23:0];
            REG_COLS: cols_sh = v[6:0];
            REG_ROWS: rows_sh = v[6:0];
            REG_NODATA: nodata_sh = v;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_grid(input int cols, input int rows, input logic signed [17:0] c,
                            input logic signed [17:0] s, input int cx, input int cy);
        write_reg(REG_COLS, cols);
        write_reg(REG_ROWS, rows);
        write_reg(REG_COS, 32'(c));
        write_reg(REG_SIN, 32'(s));
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
    endtask

    // fill every column, row and cell in use with random content
    task automatic fill_grid(input int span);
        int cols, rows;
        cols = dim_of(cols_sh);
        rows = dim_of(rows_sh);
        for (int i = 0; i < cols; i++)
            send_req(OP_LOAD_COL, i, 24'($urandom_range(2 * span) - span), 1'b0, 32'd0);
        for (int i = 0; i < rows; i++)
            send_req(OP_LOAD_ROW, i, 24'($urandom_range(2 * span) - span), 1'b0, 32'd0);
        for (int i = 0; i < cols * rows; i++)
            send_req(OP_LOAD_CELL, i, 24'd0, $urandom_range(3) != 0, $urandom);
    endtask

    function automatic int pick_query();
        int sz;
        sz = dim_of(cols_sh) * dim_of(rows_sh);
        if ($urandom_range(9) == 0) return sz + $urandom_range(CELLS - 1 - sz);
        return $urandom_range(sz - 1);
    endfunction

    // directed: extreme fields, masked cell, out-of-range query and loads
    task automatic test_directed();
        set_grid(2, 2, 18'sd65536, 18'sd0, 0, 0);
        write_reg(REG_NODATA, 32'h8000_0000);
        send_req(OP_LOAD_COL, 0, 24'h800000, 1'b0, 32'd0);
        send_req(OP_LOAD_COL, 1, 24'h7fffff, 1'b0, 32'd0);
        send_req(OP_LOAD_ROW, 0, 24'h7fffff, 1'b0, 32'd0);
        send_req(OP_LOAD_ROW, 1, 24'h800000, 1'b0, 32'd0);
        send_req(OP_LOAD_COL, 4095, 24'h123456, 1'b0, 32'd0);
        send_req(OP_LOAD_ROW, 64, 24'h654321, 1'b0, 32'd0);
        send_req(OP_LOAD_CELL, 0, 24'hffffff, 1'b1, 32'h7fff_ffff);
        send_req(OP_LOAD_CELL, 1, 24'd0, 1'b0, 32'h8000_0000);
        send_req(OP_LOAD_CELL, 2, 24'd0, 1'b1, 32'hffff_ffff);
        send_req(OP_LOAD_CELL, 3, 24'd0, 1'b1, 32'h0);
        send_req(OP_LOAD_CELL, 4095, 24'hffffff, 1'b1, 32'h5a5a_a5a5);
        for (int i = 0; i < 4; i++) send_req(OP_QUERY, i, 24'd0, 1'b0, 32'd0);
        send_req(OP_QUERY, 4095, 24'd0, 1'b0, 32'd0);
        // ties: all coordinates equal keeps the lowest index
        send_req(OP_LOAD_COL, 1, 24'h800000, 1'b0, 32'd0);
        send_req(OP_LOAD_ROW, 1, 24'h7fffff, 1'b0, 32'd0);
        send_req(OP_QUERY, 3, 24'd0, 1'b0, 32'd0);
        // extreme rotation with far centre
        set_grid(2, 2, -18'sd65536, 18'sd65536, 32'h7fffff, 32'hff800000);
        write_reg(REG_NODATA, 32'h7fff_ffff);
        send_req(OP_QUERY, 0, 24'd0, 1'b0, 32'd0);
        send_req(OP_QUERY, 2, 24'd0, 1'b0, 32'd0);
        send_req(OP_QUERY, 1, 24'd0, 1'b0, 32'd0);
    endtask

    // random phases: varied grids and angles, all small
    task automatic test_random(input int queries, input int cols, input int rows,
                               input int span);
        logic signed [17:0] c, s;
        c = 18'($urandom_range(131072) - 65536);
        s = 18'($urandom_range(131072) - 65536);
        set_grid(cols, rows, c, s, $urandom_range(2 * span) - span,
                 $urandom_range(2 * span) - span);
        write_reg(REG_NODATA, $urandom);
        fill_grid(span);
        for (int i = 0; i < queries; i++)
        begin
            if ($urandom_range(4) == 0)
                send_req(OP_LOAD_CELL, $urandom_range(dim_of(cols_sh) * dim_of(rows_sh) - 1),
                         24'($urandom), 1'($urandom), $urandom);
            send_req(OP_QUERY, pick_query(), 24'($urandom), 1'($urandom), $urandom);
        end
    endtask

    // sender holds off until every answer is back
    task automatic test_drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_answers.size() != 0) @(posedge clk);
        send_req(OP_QUERY, pick_query(), 24'd0, 1'b0, 32'd0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gap_pct = 16;
        stall_pct = 52;
        test_directed();
        test_random(10, $urandom_range(1, 4), $urandom_range(1, 4), 8388607);
        // zero grid size acts as one
        test_random(6, 0, 0, 100);
        send_gap_pct = 52;
        stall_pct = 16;
        test_random(10, $urandom_range(1, 4), $urandom_range(1, 4), 1000);
        test_drain_pause();
        send_gap_pct = 0;
        stall_pct = 0;
        test_random(10, $urandom_range(1, 8), $urandom_range(1, 8), 50);
        test_drain_pause();
        in_valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && !out_valid)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/rrncm_pkg.sv
rtl/core/rrncm_dist.sv
rtl/core/raster_rotate_nearest_cell_map_top.sv
tb/raster_rotate_nearest_cell_map_top_test.sv
